### rtl/ascii_ppm_pixel_decoder_macros.svh
// Assertion helpers for the ASCII PPM decoder RTL.
// Each macro checks one implication on the rising clock edge outside reset.
`ifndef ASCII_PPM_PIXEL_DECODER_MACROS_SVH
`define ASCII_PPM_PIXEL_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define APPD_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define APPD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define APPD_ASSERT_IMPL(label, clk, rst, pre, post, msg)
`define APPD_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

### rtl/appd_pkg.sv
`default_nettype none

package appd_pkg;

  // Width of a frame dimension accepted from the header.
  localparam int DIM_BITS = 16;

  // Largest legal width or height: the smaller of the dimension range and 16 bits.
  localparam logic [16:0] DIM_LIMIT =
    (DIM_BITS >= 16) ? 17'd65535 : 17'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [16:0] SCALE_LIMIT = 17'd65535;
  // Number accumulators stick at this value.
  localparam logic [16:0] ACC_MAX = 17'h1FFFF;

  // Characters of interest.
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_THREE = 8'h33;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_BAD_MAGIC = 3'd0;
  localparam logic [2:0] ERR_BAD_DIMS  = 3'd1;
  localparam logic [2:0] ERR_BAD_SCALE = 3'd2;
  localparam logic [2:0] ERR_STRAY     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // Where the parser stands in the file.
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_DIMS,
    PH_SCALE,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // Steps of the per-beat sequencer.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_DIVIDE,
    SQ_SAMPLE,
    SQ_TAIL
  } seq_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] scale;
    logic [23:0] pixel_rgb;
    logic [31:0] pixel_index;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  // Status of the sample scaling divider.
  typedef struct packed {
    logic       busy;
    logic [7:0] quotient;
  } div_status_t;

  // Expected character of the magic line at a given position.
  function automatic logic [7:0] magic_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CHAR_P;
      2'd1:    c = CHAR_THREE;
      2'd2:    c = CHAR_NL;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/appd_if.sv
`default_nettype none

// Byte stream channel into the decoder.
interface appd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// Result channel out of the decoder.
interface appd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] scale;
  logic [23:0] pixel_rgb;
  logic [31:0] pixel_index;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, output kind, output width, output height, output scale,
    output pixel_rgb, output pixel_index, output error_code, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input width, input height, input scale,
    input pixel_rgb, input pixel_index, input error_code, input last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/appd_divider.sv
`default_nettype none
`include "ascii_ppm_pixel_decoder_macros.svh"

// Computes min(255, 255 * sample / scale) with one compare and subtract a cycle.
// The first step checks for clipping, then eight restoring steps give the quotient.
module appd_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [16:0]               sample_value,
  input  logic [15:0]               divisor,
  output appd_pkg::div_status_t     status
);

  logic        running;
  logic [24:0] rem;
  logic [23:0] dsh;
  logic [3:0]  cnt;
  logic [7:0]  quotient;
  logic        ge;

  // Trial compare of the remainder against the shifted divisor.
  assign ge = (rem >= {1'b0, dsh});

  // Control: run from start until the clip check or the last bit step.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
    end else if (running) begin
      if ((cnt == 4'd8 && ge) || cnt == 4'd0) begin
        running <= 1'b0;
      end
    end
  end

  // Datapath: remainder, shifted divisor, step count and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {sample_value, 8'h00} - {8'h00, sample_value};
      dsh      <= {divisor, 8'h00};
      cnt      <= 4'd8;
      quotient <= 8'h00;
    end else if (running) begin
      if (cnt == 4'd8) begin
        if (ge) begin
          quotient <= 8'hFF;
        end else begin
          dsh <= dsh >> 1;
          cnt <= cnt - 4'd1;
        end
      end else begin
        if (ge) begin
          rem <= rem - {1'b0, dsh};
          quotient[cnt[2:0]] <= 1'b1;
        end
        if (cnt != 4'd0) begin
          dsh <= dsh >> 1;
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

  assign status.busy     = running;
  assign status.quotient = quotient;

  `APPD_ASSERT_NEXT(a_div_start, clk, rst, start, running && cnt == 4'd8, "divider did not start")
  `APPD_ASSERT_IMPL(a_div_count, clk, rst, running, cnt <= 4'd8, "divider step count out of range")
  `APPD_ASSERT_NEXT(a_div_stop, clk, rst, running && cnt == 4'd0 && !start, !running, "divider overran")

endmodule

`default_nettype wire

### rtl/appd_out_stage.sv
`default_nettype none

// Output register: holds one result beat until the sink takes it.
module appd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  appd_pkg::result_t    res,
  output logic                 slot_free,
  appd_out_if.source           result
);

  logic              valid;
  appd_pkg::result_t held;

  // The slot can take a new beat when empty or being emptied this cycle.
  assign slot_free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid       = valid;
  assign result.kind        = held.kind;
  assign result.width       = held.width;
  assign result.height      = held.height;
  assign result.scale       = held.scale;
  assign result.pixel_rgb   = held.pixel_rgb;
  assign result.pixel_index = held.pixel_index;
  assign result.error_code  = held.error_code;
  assign result.last        = held.last;

endmodule

`default_nettype wire

### rtl/ascii_ppm_pixel_decoder.sv
`default_nettype none
`include "ascii_ppm_pixel_decoder_macros.svh"

// ASCII PPM (P3) decoder. Bytes of the file arrive one beat each on stream, with
// end_of_file marking a beat that carries no byte and returns the block to its
// start for the next file. Results leave on result: a header beat after the scale
// line, one pixel beat per three samples (255 * x / scale, clipped to 255, red in
// bits 23..16), a frame done beat and error beats; last marks the final result of
// an input beat, and at most two results follow one beat. The block takes one byte
// at a time and is not ready while it works on it: a plain byte is only decoded, a
// separator in the pixel data is then checked for the frame end, and a separator
// or end of stream that completes a sample goes through the divider and the sample
// step before that check; the division ends early when the clip check hits. The
// shared compare and subtract divider does that clip check first, then one quotient
// bit per cycle. A result that waits for a full output register stalls the block.
module ascii_ppm_pixel_decoder (
  input  logic       clk,
  input  logic       rst,
  appd_in_if.sink    stream,
  appd_out_if.source result
);

  appd_pkg::seq_t   state, state_next;
  appd_pkg::phase_t phase, phase_next;

  logic [7:0]  byte_r;
  logic        eof_r;
  logic [1:0]  magic_position, magic_position_next;
  logic        at_line_start, at_line_start_next;
  logic        in_comment_line, in_comment_line_next;
  logic        in_number, in_number_next;
  logic [16:0] acc, acc_next;
  logic [1:0]  hdr_count, hdr_count_next;
  logic [15:0] frame_width, frame_width_next;
  logic [15:0] frame_height, frame_height_next;
  logic [15:0] sample_scale, sample_scale_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [31:0] next_pixel_index, next_pixel_index_next;
  logic [1:0]  sample_count, sample_count_next;
  logic [7:0]  held_red, held_red_next;
  logic [7:0]  held_green, held_green_next;

  appd_pkg::result_t     res;
  appd_pkg::div_status_t div_stat;
  logic res_want, res_load, slot_free, advance;
  logic go_divide, go_tail, clear_frame, div_start;

  logic        is_digit, is_space, is_nl, nl_data;
  logic [20:0] acc_grown;
  logic        num_fail;
  logic [1:0]  cnt_after, need;
  logic [2:0]  num_code;
  logic [31:0] pixels_after;

  // Character classes of the held byte.
  assign is_digit = byte_r inside {[appd_pkg::CHAR_ZERO:appd_pkg::CHAR_NINE]};
  assign is_space = byte_r inside {appd_pkg::CHAR_SPACE,
                                   [appd_pkg::CHAR_TAB:appd_pkg::CHAR_CR]};
  assign is_nl    = (byte_r == appd_pkg::CHAR_NL);
  assign nl_data  = !eof_r && is_nl;

  // Decimal accumulate before saturation.
  assign acc_grown = 21'(acc) * 21'd10 + 21'(byte_r - appd_pkg::CHAR_ZERO);

  // Header number end: validity and the field count it leaves.
  assign need     = (phase == appd_pkg::PH_DIMS) ? 2'd2 : 2'd1;
  assign num_code = (phase == appd_pkg::PH_DIMS) ? appd_pkg::ERR_BAD_DIMS
                                                 : appd_pkg::ERR_BAD_SCALE;
  always_comb begin
    num_fail  = 1'b0;
    cnt_after = hdr_count;
    if (in_number) begin
      if (phase == appd_pkg::PH_DIMS) begin
        num_fail = (acc == 17'd0) || (acc > appd_pkg::DIM_LIMIT);
      end else begin
        num_fail = (acc == 17'd0) || (acc > appd_pkg::SCALE_LIMIT);
      end
      if (!num_fail) begin
        cnt_after = hdr_count + 2'd1;
      end
    end
  end

  assign pixels_after = pixels_left - 32'd1;

  // Parser update for the current sequencer step.
  always_comb begin
    phase_next            = phase;
    magic_position_next   = magic_position;
    at_line_start_next    = at_line_start;
    in_comment_line_next  = in_comment_line;
    in_number_next        = in_number;
    acc_next              = acc;
    hdr_count_next        = hdr_count;
    frame_width_next      = frame_width;
    frame_height_next     = frame_height;
    sample_scale_next     = sample_scale;
    pixels_left_next      = pixels_left;
    next_pixel_index_next = next_pixel_index;
    sample_count_next     = sample_count;
    held_red_next         = held_red;
    held_green_next       = held_green;
    res         = '0;
    res_want    = 1'b0;
    go_divide   = 1'b0;
    go_tail     = 1'b0;
    clear_frame = 1'b0;

    case (state)
      appd_pkg::SQ_DECODE: begin
        if (eof_r) begin
          // End of stream.
          if (phase == appd_pkg::PH_MAGIC) begin
            res_want       = 1'b1;
            res.kind       = appd_pkg::KIND_ERROR;
            res.error_code = appd_pkg::ERR_BAD_MAGIC;
            res.last       = 1'b1;
            clear_frame    = 1'b1;
          end else if (phase inside {appd_pkg::PH_DIMS, appd_pkg::PH_SCALE}) begin
            res_want       = 1'b1;
            res.kind       = appd_pkg::KIND_ERROR;
            res.error_code = appd_pkg::ERR_TRUNCATED;
            res.last       = 1'b1;
            clear_frame    = 1'b1;
          end else if (phase == appd_pkg::PH_DATA) begin
            go_divide      = in_number && (pixels_left != 32'd0);
            go_tail        = !go_divide;
            in_number_next = 1'b0;
            acc_next       = '0;
          end else begin
            clear_frame = 1'b1;
          end
        end else if (phase == appd_pkg::PH_MAGIC) begin
          // Magic line, matched exactly.
          if (magic_position != 2'd3 && byte_r == appd_pkg::magic_char(magic_position)) begin
            magic_position_next = magic_position + 2'd1;
            if (magic_position == 2'd2) begin
              phase_next         = appd_pkg::PH_DIMS;
              at_line_start_next = 1'b1;
            end
          end else begin
            res_want       = 1'b1;
            res.kind       = appd_pkg::KIND_ERROR;
            res.error_code = appd_pkg::ERR_BAD_MAGIC;
            res.last       = 1'b1;
            phase_next     = appd_pkg::PH_ERROR;
          end
        end else if (phase inside {appd_pkg::PH_DIMS, appd_pkg::PH_SCALE,
                                   appd_pkg::PH_DATA}) begin
          if (in_comment_line) begin
            // Inside a comment line until its newline.
            if (is_nl) begin
              in_comment_line_next = 1'b0;
              at_line_start_next   = 1'b1;
            end
          end else if (at_line_start && byte_r == appd_pkg::CHAR_HASH) begin
            in_comment_line_next = 1'b1;
            at_line_start_next   = 1'b0;
          end else begin
            at_line_start_next = is_nl;
            if (is_digit) begin
              // Digit: grow the number unless the header line is already full.
              if (phase == appd_pkg::PH_DATA || hdr_count < need) begin
                acc_next = (acc_grown > 21'(appd_pkg::ACC_MAX)) ? appd_pkg::ACC_MAX
                                                                : acc_grown[16:0];
                in_number_next = 1'b1;
              end
            end else if (phase == appd_pkg::PH_DATA) begin
              if (is_space) begin
                // Separator in the data: scale a finished sample, then check the line end.
                go_divide      = in_number && (pixels_left != 32'd0);
                go_tail        = !go_divide;
                in_number_next = 1'b0;
                acc_next       = '0;
              end else begin
                res_want       = 1'b1;
                res.kind       = appd_pkg::KIND_ERROR;
                res.error_code = appd_pkg::ERR_STRAY;
                res.last       = 1'b1;
                phase_next     = appd_pkg::PH_ERROR;
              end
            end else begin
              // Any other byte in a header line ends the current number.
              in_number_next = 1'b0;
              acc_next       = '0;
              hdr_count_next = cnt_after;
              if (in_number && !num_fail) begin
                if (phase == appd_pkg::PH_SCALE) begin
                  sample_scale_next = acc[15:0];
                end else if (hdr_count == 2'd0) begin
                  frame_width_next = acc[15:0];
                end else begin
                  frame_height_next = acc[15:0];
                end
              end
              if (in_number && num_fail) begin
                res_want       = 1'b1;
                res.kind       = appd_pkg::KIND_ERROR;
                res.error_code = num_code;
                res.last       = 1'b1;
                phase_next     = appd_pkg::PH_ERROR;
              end else if (is_space) begin
                if (is_nl) begin
                  if (cnt_after < need) begin
                    res_want       = 1'b1;
                    res.kind       = appd_pkg::KIND_ERROR;
                    res.error_code = num_code;
                    res.last       = 1'b1;
                    phase_next     = appd_pkg::PH_ERROR;
                  end else if (phase == appd_pkg::PH_DIMS) begin
                    pixels_left_next = 32'(frame_width_next) * 32'(frame_height_next);
                    phase_next       = appd_pkg::PH_SCALE;
                    hdr_count_next   = 2'd0;
                  end else begin
                    res_want   = 1'b1;
                    res.kind   = appd_pkg::KIND_HEADER;
                    res.width  = frame_width;
                    res.height = frame_height;
                    res.scale  = sample_scale_next;
                    res.last   = 1'b1;
                    phase_next = appd_pkg::PH_DATA;
                  end
                end
              end else if (cnt_after < need) begin
                res_want       = 1'b1;
                res.kind       = appd_pkg::KIND_ERROR;
                res.error_code = num_code;
                res.last       = 1'b1;
                phase_next     = appd_pkg::PH_ERROR;
              end
            end
          end
        end
      end

      appd_pkg::SQ_SAMPLE: begin
        // Place the scaled sample; the third one of a pixel goes out.
        if (sample_count == 2'd0) begin
          held_red_next     = div_stat.quotient;
          sample_count_next = 2'd1;
        end else if (sample_count == 2'd1) begin
          held_green_next   = div_stat.quotient;
          sample_count_next = 2'd2;
        end else begin
          res_want              = 1'b1;
          res.kind              = appd_pkg::KIND_PIXEL;
          res.pixel_rgb         = {held_red, held_green, div_stat.quotient};
          res.pixel_index       = next_pixel_index;
          res.last              = !(eof_r || (nl_data && pixels_after == 32'd0));
          sample_count_next     = 2'd0;
          next_pixel_index_next = next_pixel_index + 32'd1;
          pixels_left_next      = pixels_after;
        end
      end

      appd_pkg::SQ_TAIL: begin
        // Frame end check after a data separator or end of stream.
        if (eof_r) begin
          res_want    = 1'b1;
          res.last    = 1'b1;
          clear_frame = 1'b1;
          if (pixels_left == 32'd0) begin
            res.kind   = appd_pkg::KIND_DONE;
            res.width  = frame_width;
            res.height = frame_height;
            res.scale  = sample_scale;
          end else begin
            res.kind       = appd_pkg::KIND_ERROR;
            res.error_code = appd_pkg::ERR_TRUNCATED;
          end
        end else if (is_nl && pixels_left == 32'd0) begin
          res_want   = 1'b1;
          res.kind   = appd_pkg::KIND_DONE;
          res.width  = frame_width;
          res.height = frame_height;
          res.scale  = sample_scale;
          res.last   = 1'b1;
          phase_next = appd_pkg::PH_DONE;
        end
      end

      default: begin
      end
    endcase

    // End of stream returns the parser to its start.
    if (clear_frame) begin
      phase_next            = appd_pkg::PH_MAGIC;
      magic_position_next   = 2'd0;
      at_line_start_next    = 1'b1;
      in_comment_line_next  = 1'b0;
      in_number_next        = 1'b0;
      acc_next              = '0;
      hdr_count_next        = 2'd0;
      frame_width_next      = '0;
      frame_height_next     = '0;
      sample_scale_next     = 16'd1;
      pixels_left_next      = '0;
      next_pixel_index_next = '0;
      sample_count_next     = 2'd0;
      held_red_next         = '0;
      held_green_next       = '0;
    end
  end

  // A step that has a result waits until the output register can take it.
  assign advance = !(res_want && !slot_free);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      appd_pkg::SQ_IDLE: begin
        if (stream.valid) begin
          state_next = appd_pkg::SQ_DECODE;
        end
      end
      appd_pkg::SQ_DECODE: begin
        if (advance) begin
          if (go_divide) begin
            state_next = appd_pkg::SQ_DIVIDE;
          end else if (go_tail) begin
            state_next = appd_pkg::SQ_TAIL;
          end else begin
            state_next = appd_pkg::SQ_IDLE;
          end
        end
      end
      appd_pkg::SQ_DIVIDE: begin
        if (!div_stat.busy) begin
          state_next = appd_pkg::SQ_SAMPLE;
        end
      end
      appd_pkg::SQ_SAMPLE: begin
        if (advance) begin
          state_next = appd_pkg::SQ_TAIL;
        end
      end
      appd_pkg::SQ_TAIL: begin
        if (advance) begin
          state_next = appd_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_next = appd_pkg::SQ_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    stream.ready = (state == appd_pkg::SQ_IDLE);
    div_start    = (state == appd_pkg::SQ_DECODE) && go_divide;
    res_load     = res_want && slot_free;
  end

  // Sequencer and parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= appd_pkg::SQ_IDLE;
      phase            <= appd_pkg::PH_MAGIC;
      magic_position   <= 2'd0;
      at_line_start    <= 1'b1;
      in_comment_line  <= 1'b0;
      in_number        <= 1'b0;
      acc              <= '0;
      hdr_count        <= 2'd0;
      frame_width      <= '0;
      frame_height     <= '0;
      sample_scale     <= 16'd1;
      pixels_left      <= '0;
      next_pixel_index <= '0;
      sample_count     <= 2'd0;
      held_red         <= '0;
      held_green       <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        phase            <= phase_next;
        magic_position   <= magic_position_next;
        at_line_start    <= at_line_start_next;
        in_comment_line  <= in_comment_line_next;
        in_number        <= in_number_next;
        acc              <= acc_next;
        hdr_count        <= hdr_count_next;
        frame_width      <= frame_width_next;
        frame_height     <= frame_height_next;
        sample_scale     <= sample_scale_next;
        pixels_left      <= pixels_left_next;
        next_pixel_index <= next_pixel_index_next;
        sample_count     <= sample_count_next;
        held_red         <= held_red_next;
        held_green       <= held_green_next;
      end
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      byte_r <= stream.data_byte;
      eof_r  <= stream.end_of_file;
    end
  end

  appd_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .sample_value (acc),
    .divisor      (sample_scale),
    .status       (div_stat)
  );

  appd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .slot_free (slot_free),
    .result    (result)
  );

  `APPD_ASSERT_NEXT(a_accept_decode, clk, rst, stream.valid && stream.ready, state == appd_pkg::SQ_DECODE, "accepted beat not decoded")
  `APPD_ASSERT_NEXT(a_start_divide, clk, rst, div_start, state == appd_pkg::SQ_DIVIDE && div_stat.busy, "divider start lost")
  `APPD_ASSERT_IMPL(a_sample_count, clk, rst, phase == appd_pkg::PH_DATA, sample_count != 2'd3, "sample count out of range")

endmodule

`default_nettype wire
